// ===== src/snz_pkg.sv =====
// ----------------------------------------------------------------------------
// snz_pkg: shared constants and tables for the 3D simplex noise unit
// Fixed-point formats, the permutation table and the gradient index table.
// ----------------------------------------------------------------------------
package snz_pkg;

    localparam int FRAC_BITS_DEF = 16;   // default fraction bits of the coordinates
    localparam int OFS_BITS      = 20;   // fraction bits of the rounded corner offsets
    localparam int COORD_W       = 32;
    localparam int NOISE_W       = 16;
    localparam int OFS_HW        = 25;   // half-scaled offset before the divide by three
    localparam int CX_W          = 23;   // corner offset component, Q.20
    localparam int DP_W          = 24;   // gradient dot product, Q.20
    localparam int T_W           = 20;   // falloff and its powers, Q.20
    localparam int SQ_W          = 44;   // one squared component, Q.40
    localparam int R2_W          = 46;   // squared distance, Q.40
    localparam int CT_W          = 46;   // one corner contribution, Q.40
    localparam int SUM_W         = 48;   // sum of four contributions

    // 0.6 in Q.40
    localparam logic [39:0] FALLOFF = 40'd659706976666;

    typedef logic [7:0] perm_tab_t [256];
    typedef logic [3:0] gidx_tab_t [256];

    localparam perm_tab_t PERM = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    // The last hash level only needs the gradient index, so it is tabulated directly.
    function automatic gidx_tab_t build_gidx();
        gidx_tab_t tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = 4'(PERM[i] % 12);
        end
        return tab;
    endfunction

    localparam gidx_tab_t GIDX = build_gidx();

endpackage

// ===== src/snz_div3.sv =====
// ----------------------------------------------------------------------------
// snz_div3: pipelined floor division by three
// Signed input, two register stages: reciprocal multiply, then one correction.
// ----------------------------------------------------------------------------
module snz_div3 #(
    parameter int W = 25
) (
    input  logic                aclk,
    input  logic                ce,
    input  logic signed [W-1:0] din,
    output logic signed [W-1:0] qout
);
    localparam int NW = W + 1;
    // The bias is a multiple of three that makes the dividend non-negative.
    localparam logic [NW-1:0] BIAS  = NW'(64'd3 << (W - 2));
    localparam logic [NW-1:0] QOFS  = NW'(64'd1 << (W - 2));
    localparam logic [NW-1:0] RECIP = NW'((64'd1 << NW) / 3);

    logic [NW-1:0]   n_next;
    logic [NW-1:0]   n_reg;
    logic [2*NW-1:0] prod_next;
    logic [2*NW-1:0] prod_reg;
    logic [NW-1:0]   q_est;
    logic [NW-1:0]   rem;
    logic [NW-1:0]   q_fix;
    logic signed [W-1:0] qout_reg;

    assign n_next    = NW'(din) + BIAS;
    assign prod_next = n_next * RECIP;

    // The estimate is never more than one below the true quotient.
    assign q_est = prod_reg[2*NW-1:NW];
    assign rem   = n_reg - ((q_est << 1) + q_est);
    assign q_fix = q_est + NW'(rem >= NW'(3));

    always_ff @(posedge aclk) begin
        if (ce) begin
            n_reg    <= n_next;
            prod_reg <= prod_next;
            qout_reg <= W'(q_fix - QOFS);
        end
    end

    assign qout = qout_reg;

endmodule

// ===== src/snz_hash.sv =====
// ----------------------------------------------------------------------------
// snz_hash: three-level permutation hash of one lattice corner
// One table lookup per stage; the result is a gradient index from 0 to 11.
// ----------------------------------------------------------------------------
module snz_hash (
    input  logic       aclk,
    input  logic       ce,
    input  logic [7:0] cell_a,
    input  logic [7:0] cell_b,
    input  logic [7:0] cell_c,
    output logic [3:0] gidx
);
    import snz_pkg::*;

    logic [7:0] h1_reg;
    logic [7:0] a1_reg;
    logic [7:0] b1_reg;
    logic [7:0] h2_reg;
    logic [7:0] a2_reg;
    logic [3:0] g_reg;
    logic [7:0] idx2;
    logic [7:0] idx3;

    assign idx2 = b1_reg + h1_reg;
    assign idx3 = a2_reg + h2_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            h1_reg <= PERM[cell_c];
            a1_reg <= cell_a;
            b1_reg <= cell_b;
            h2_reg <= PERM[idx2];
            a2_reg <= a1_reg;
            g_reg  <= GIDX[idx3];
        end
    end

    assign gidx = g_reg;

endmodule

// ===== src/snz_corner.sv =====
// ----------------------------------------------------------------------------
// snz_corner: contribution of one simplex corner
// Rounds the offset to Q.20, hashes the corner, and forms (0.6 - r^2)^4 * dot.
// ----------------------------------------------------------------------------
module snz_corner #(
    parameter int FRAC_BITS = snz_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             ce,
    input  logic signed [FRAC_BITS+4:0]      d_x,
    input  logic signed [FRAC_BITS+4:0]      d_y,
    input  logic signed [FRAC_BITS+4:0]      d_z,
    input  logic [7:0]                       cell_a,
    input  logic [7:0]                       cell_b,
    input  logic [7:0]                       cell_c,
    output logic signed [snz_pkg::CT_W-1:0]  contrib
);
    import snz_pkg::*;

    localparam int DW = FRAC_BITS + 5;
    localparam int TW = OFS_HW + 1;

    logic signed [DW-1:0]     d       [3];
    logic signed [TW-1:0]     sh      [3];
    logic signed [TW-1:0]     rnd     [3];
    logic signed [OFS_HW-1:0] half_reg[3];
    logic signed [OFS_HW-1:0] q       [3];
    logic signed [CX_W-1:0]   cx      [3];
    logic signed [2*CX_W-1:0] sq_full [3];
    logic [SQ_W-1:0]          sq_reg  [3];
    logic [3:0]               gidx;
    logic signed [DP_W-1:0]   dp_next;
    logic signed [DP_W-1:0]   dp_reg  [4];
    logic [R2_W-1:0]          r2;
    logic signed [R2_W+1:0]   tdiff;
    logic [T_W-1:0]           t_reg;
    logic [2*T_W-1:0]         tsq;
    logic [T_W-1:0]           t2_reg;
    logic [2*T_W-1:0]         t2sq;
    logic [T_W-1:0]           t4_reg;
    logic signed [CT_W-1:0]   prod;
    logic signed [CT_W-1:0]   contrib_reg;

    assign d[0] = d_x;
    assign d[1] = d_y;
    assign d[2] = d_z;

    // Offset rounding: floor((d * 2^20 + 3 * 2^F) / (6 * 2^F)), taken as
    // a shift to Q.20, a half-up add, a halving and a divide by three.
    for (genvar k = 0; k < 3; k++) begin : g_axis
        if (FRAC_BITS <= OFS_BITS) begin : g_up
            assign sh[k] = TW'(d[k]) <<< (OFS_BITS - FRAC_BITS);
        end else begin : g_down
            assign sh[k] = TW'(d[k] >>> (FRAC_BITS - OFS_BITS));
        end
        assign rnd[k] = sh[k] + TW'(3);

        snz_div3 #(.W(OFS_HW)) u_div3 (
            .aclk (aclk),
            .ce   (ce),
            .din  (half_reg[k]),
            .qout (q[k])
        );

        assign cx[k]      = CX_W'(q[k]);
        assign sq_full[k] = cx[k] * cx[k];
    end

    snz_hash u_hash (
        .aclk   (aclk),
        .ce     (ce),
        .cell_a (cell_a),
        .cell_b (cell_b),
        .cell_c (cell_c),
        .gidx   (gidx)
    );

    always_comb begin
        logic signed [DP_W-1:0] ex;
        logic signed [DP_W-1:0] ey;
        logic signed [DP_W-1:0] ez;
        ex = DP_W'(cx[0]);
        ey = DP_W'(cx[1]);
        ez = DP_W'(cx[2]);
        unique case (gidx)
            4'd0:    dp_next =  ex + ey;
            4'd1:    dp_next = -ex + ey;
            4'd2:    dp_next =  ex - ey;
            4'd3:    dp_next = -ex - ey;
            4'd4:    dp_next =  ex + ez;
            4'd5:    dp_next = -ex + ez;
            4'd6:    dp_next =  ex - ez;
            4'd7:    dp_next = -ex - ez;
            4'd8:    dp_next =  ey + ez;
            4'd9:    dp_next = -ey + ez;
            4'd10:   dp_next =  ey - ez;
            4'd11:   dp_next = -ey - ez;
            default: dp_next = '0;
        endcase
    end

    assign r2    = R2_W'(sq_reg[0]) + R2_W'(sq_reg[1]) + R2_W'(sq_reg[2]);
    assign tdiff = $signed({8'd0, FALLOFF}) - $signed({2'd0, r2});
    assign tsq   = t_reg * t_reg;
    assign t2sq  = t2_reg * t2_reg;
    assign prod  = $signed({1'b0, t4_reg}) * dp_reg[3];

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                half_reg[k] <= OFS_HW'(rnd[k] >>> 1);
                sq_reg[k]   <= sq_full[k][SQ_W-1:0];
            end
            dp_reg[0] <= dp_next;
            for (int k = 1; k < 4; k++) begin
                dp_reg[k] <= dp_reg[k-1];
            end
            // A corner outside the falloff radius adds nothing.
            t_reg       <= (tdiff > 0) ? tdiff[OFS_BITS+T_W-1:OFS_BITS] : '0;
            t2_reg      <= tsq[OFS_BITS+T_W-1:OFS_BITS];
            t4_reg      <= t2sq[OFS_BITS+T_W-1:OFS_BITS];
            contrib_reg <= prod;
        end
    end

    assign contrib = contrib_reg;

endmodule

// ===== src/simplex_noise_3d_unit.sv =====
// ----------------------------------------------------------------------------
// simplex_noise_3d_unit: pipelined 3D simplex noise evaluator
// One point in, one Q1.14 noise value out, fully pipelined.
// ----------------------------------------------------------------------------
// The unit accepts one point per clock while no result waits on a stalled
// output, and delivers results in request order. The pipeline runs through
// cell search by a divide by three, offset rounding by a second divide
// by three and the permutation hash in parallel, then the falloff
// squaring chain and the final sum and saturation. When the output
// is not taken the whole pipeline holds, so s_axis_tready follows
// m_axis_tready while a result is waiting.
module simplex_noise_3d_unit #(
    parameter int FRAC_BITS = snz_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] coord_x, [63:32] coord_y, [95:64] coord_z
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] noise_value
    output logic [15:0] m_axis_tdata
);
    import snz_pkg::*;

    localparam int SW    = COORD_W + 3;
    localparam int QW    = SW - FRAC_BITS;
    localparam int DW    = FRAC_BITS + 5;
    localparam int DEPTH = 16;

    localparam logic signed [DW-1:0] ONE = DW'(1) << FRAC_BITS;
    localparam logic signed [DW-1:0] SIX = DW'(6) << FRAC_BITS;

    logic ce;
    logic [DEPTH-1:0] valid_reg;

    logic signed [COORD_W-1:0] c0_reg [3];
    logic signed [COORD_W-1:0] c1_reg [3];
    logic signed [COORD_W-1:0] c2_reg [3];
    logic signed [COORD_W-1:0] c3_reg [3];
    logic signed [SW-1:0]      ssum   [3];
    logic signed [QW-1:0]      q1_reg [3];
    logic signed [QW-1:0]      cell_idx[3];
    logic [4:0]                base5;
    logic signed [DW-1:0]      d_next [3];
    logic signed [DW-1:0]      d_reg  [3];
    logic [7:0]                cb_reg [3];
    logic                      a1, b1, c1, a2, b2, c2;
    logic signed [DW-1:0]      cd_reg [4][3];
    logic [7:0]                ck_reg [4][3];
    logic signed [CT_W-1:0]    contrib[4];
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SUM_W-1:0]   rounded;
    logic [NOISE_W-1:0]        noise_reg;
    logic [NOISE_W-1:0]        noise_next;

    assign ce            = !valid_reg[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = ce;
    assign m_axis_tvalid = valid_reg[DEPTH-1];
    assign m_axis_tdata  = noise_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ce) begin
            valid_reg <= {valid_reg[DEPTH-2:0], s_axis_tvalid};
        end
    end

    // Skewed cell sums: 4c plus the other two coordinates.
    assign ssum[0] = (SW'(c0_reg[0]) <<< 2) + SW'(c0_reg[1]) + SW'(c0_reg[2]);
    assign ssum[1] = (SW'(c0_reg[1]) <<< 2) + SW'(c0_reg[0]) + SW'(c0_reg[2]);
    assign ssum[2] = (SW'(c0_reg[2]) <<< 2) + SW'(c0_reg[0]) + SW'(c0_reg[1]);

    for (genvar k = 0; k < 3; k++) begin : g_cell
        snz_div3 #(.W(QW)) u_div3 (
            .aclk (aclk),
            .ce   (ce),
            .din  (q1_reg[k]),
            .qout (cell_idx[k])
        );
    end

    // Only the low bits of the cell index survive in an offset that fits DW bits.
    assign base5 = cell_idx[0][4:0] + cell_idx[1][4:0] + cell_idx[2][4:0];

    always_comb begin
        logic signed [DW-1:0] xl;
        logic [4:0]           kk;
        for (int k = 0; k < 3; k++) begin
            xl        = c3_reg[k][DW-1:0];
            kk        = base5 - (cell_idx[k][4:0] << 2) - (cell_idx[k][4:0] << 1);
            d_next[k] = (xl <<< 2) + (xl <<< 1) + $signed({kk, {FRAC_BITS{1'b0}}});
        end
    end

    always_comb begin
        if (d_reg[0] >= d_reg[1]) begin
            if (d_reg[1] >= d_reg[2]) begin
                {a1, b1, c1, a2, b2, c2} = 6'b100_110;
            end else if (d_reg[0] >= d_reg[2]) begin
                {a1, b1, c1, a2, b2, c2} = 6'b100_101;
            end else begin
                {a1, b1, c1, a2, b2, c2} = 6'b001_101;
            end
        end else begin
            if (d_reg[1] < d_reg[2]) begin
                {a1, b1, c1, a2, b2, c2} = 6'b001_011;
            end else if (d_reg[0] < d_reg[2]) begin
                {a1, b1, c1, a2, b2, c2} = 6'b010_011;
            end else begin
                {a1, b1, c1, a2, b2, c2} = 6'b010_110;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                c0_reg[k] <= s_axis_tdata[k*COORD_W +: COORD_W];
                c1_reg[k] <= c0_reg[k];
                c2_reg[k] <= c1_reg[k];
                c3_reg[k] <= c2_reg[k];
                q1_reg[k] <= QW'(ssum[k] >>> FRAC_BITS);
                d_reg[k]  <= d_next[k];
                cb_reg[k] <= cell_idx[k][7:0];
            end

            cd_reg[0][0] <= d_reg[0];
            cd_reg[0][1] <= d_reg[1];
            cd_reg[0][2] <= d_reg[2];
            cd_reg[1][0] <= d_reg[0] - (a1 ? SIX : '0) + ONE;
            cd_reg[1][1] <= d_reg[1] - (b1 ? SIX : '0) + ONE;
            cd_reg[1][2] <= d_reg[2] - (c1 ? SIX : '0) + ONE;
            cd_reg[2][0] <= d_reg[0] - (a2 ? SIX : '0) + (ONE <<< 1);
            cd_reg[2][1] <= d_reg[1] - (b2 ? SIX : '0) + (ONE <<< 1);
            cd_reg[2][2] <= d_reg[2] - (c2 ? SIX : '0) + (ONE <<< 1);
            cd_reg[3][0] <= d_reg[0] - SIX + (ONE <<< 1) + ONE;
            cd_reg[3][1] <= d_reg[1] - SIX + (ONE <<< 1) + ONE;
            cd_reg[3][2] <= d_reg[2] - SIX + (ONE <<< 1) + ONE;

            ck_reg[0][0] <= cb_reg[0];
            ck_reg[0][1] <= cb_reg[1];
            ck_reg[0][2] <= cb_reg[2];
            ck_reg[1][0] <= cb_reg[0] + 8'(a1);
            ck_reg[1][1] <= cb_reg[1] + 8'(b1);
            ck_reg[1][2] <= cb_reg[2] + 8'(c1);
            ck_reg[2][0] <= cb_reg[0] + 8'(a2);
            ck_reg[2][1] <= cb_reg[1] + 8'(b2);
            ck_reg[2][2] <= cb_reg[2] + 8'(c2);
            ck_reg[3][0] <= cb_reg[0] + 8'd1;
            ck_reg[3][1] <= cb_reg[1] + 8'd1;
            ck_reg[3][2] <= cb_reg[2] + 8'd1;

            sum_reg   <= SUM_W'(contrib[0]) + SUM_W'(contrib[1])
                       + SUM_W'(contrib[2]) + SUM_W'(contrib[3]);
            noise_reg <= noise_next;
        end
    end

    for (genvar j = 0; j < 4; j++) begin : g_corner
        snz_corner #(.FRAC_BITS(FRAC_BITS)) u_corner (
            .aclk    (aclk),
            .ce      (ce),
            .d_x     (cd_reg[j][0]),
            .d_y     (cd_reg[j][1]),
            .d_z     (cd_reg[j][2]),
            .cell_a  (ck_reg[j][0]),
            .cell_b  (ck_reg[j][1]),
            .cell_c  (ck_reg[j][2]),
            .contrib (contrib[j])
        );
    end

    // Scale by 32 and round half up to Q1.14, then clamp.
    assign rounded = (sum_reg + (SUM_W'(1) <<< 20)) >>> 21;

    always_comb begin
        if (rounded > SUM_W'(32767)) begin
            noise_next = NOISE_W'(16'h7fff);
        end else if (rounded < -SUM_W'(32768)) begin
            noise_next = NOISE_W'(16'h8000);
        end else begin
            noise_next = rounded[NOISE_W-1:0];
        end
    end

endmodule

// ===== src/snz_checker.sv =====
// ----------------------------------------------------------------------------
// snz_checker: port-level checks for the simplex noise unit
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module snz_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [95:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // A result that is not taken stays offered unchanged.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output request dropped or changed while stalled");

    // A waiting input request stays offered unchanged.
    a_src_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
        else $error("input request dropped or changed while stalled");

    // The input side only stalls while a finished result is waiting.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    // A stalled pipeline brings no new result forward.
    a_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |=> $stable(m_axis_tvalid))
        else $error("output changed while pipeline stalled");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind simplex_noise_3d_unit snz_checker u_snz_checker (.*);
